@@ hw/rtl/ptss_pkg.sv @@
// shared types, codes and constants for the priority task scheduler
`default_nettype none

package ptss_pkg;

    localparam int NUM_SLOTS_DEF = 8;
    localparam int PRIO_BITS_DEF = 8;

    localparam int TIME_W = 32;
    localparam int CMD_W  = 3;
    localparam int SLOT_FIELD_W = 3;
    localparam int MASK_W = 8;
    localparam int PRIO_FIELD_W = 8;

    localparam logic [TIME_W-1:0] WAKE_NEVER = '1;

    typedef enum logic [1:0] {
        ST_UNUSED = 2'd0,
        ST_READY  = 2'd1,
        ST_WAIT   = 2'd2
    } t_status;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK     = 3'd0,
        CMD_YIELD    = 3'd1,
        CMD_CREATE   = 3'd2,
        CMD_WAIT     = 3'd3,
        CMD_SET_PRIO = 3'd4
    } t_cmd;

    // verdict of the shared compare unit for the slot under the scan index
    typedef struct packed {
        logic wake_hit;
        logic take;
    } t_eval;

endpackage

`default_nettype wire

@@ hw/rtl/ptss_eval.sv @@
// shared slot compare unit: wake-time check in the wake pass, priority check in the scan pass
`default_nettype none

module ptss_eval
    import ptss_pkg::*;
#(
    parameter int PRIO_BITS = PRIO_BITS_DEF
) (
    input  wire logic                 i_wake_phase,
    input  wire t_status              i_status,
    input  wire logic [TIME_W-1:0]    i_wake_time,
    input  wire logic [TIME_W-1:0]    i_tick,
    input  wire logic [PRIO_BITS-1:0] i_prio,
    input  wire logic [PRIO_BITS-1:0] i_best_prio,
    input  wire logic                 i_have,
    output t_eval                     o_eval
);

    logic [TIME_W-1:0] op_a;
    logic [TIME_W-1:0] op_b;
    logic              a_le_b;

    // one comparator serves both passes
    assign op_a   = i_wake_phase ? i_wake_time : TIME_W'(i_prio);
    assign op_b   = i_wake_phase ? i_tick      : TIME_W'(i_best_prio);
    assign a_le_b = (op_a <= op_b);

    assign o_eval.wake_hit = i_wake_phase && (i_status == ST_WAIT) && a_le_b;
    // strictly higher priority, or anything ready when nothing is held yet
    assign o_eval.take     = !i_wake_phase && (i_status == ST_READY)
                             && (!i_have || !a_le_b);

endmodule

`default_nettype wire

@@ hw/rtl/priority_task_scheduler_with_sleep_unit.sv @@
// top level of the fixed-priority task scheduler with sleeping slots
// a tick runs one wake pass and one selection pass between accept and its result strobe,
//   one slot per cycle through the shared compare unit
// yield, create, wait and set-priority give their result in the next cycle; busy stays low for them
// a new command is taken in the cycle its predecessor's result is on the ports
// synchronous active-low reset: tick 0, slot 0 running, all slots unused, priority 0,
//   wake times all ones; the result strobe cannot be stalled by the receiver
`default_nettype none

module priority_task_scheduler_with_sleep_unit
    import ptss_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF,
    parameter int PRIO_BITS = PRIO_BITS_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic [CMD_W-1:0]        i_cmd,
    input  wire logic [SLOT_FIELD_W-1:0] i_task_slot,
    input  wire logic [TIME_W-1:0]       i_due_time,
    input  wire logic [PRIO_FIELD_W-1:0] i_priority_value,
    output logic                         o_done,
    output logic [SLOT_FIELD_W-1:0]      o_running_slot,
    output logic                         o_switched,
    output logic [MASK_W-1:0]            o_woken_mask,
    output logic [TIME_W-1:0]            o_tick_now
);

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WAKE,
        S_INIT,
        S_SCAN
    } t_state;

    t_state               r_state;
    t_status              r_status [NUM_SLOTS];
    logic [PRIO_BITS-1:0] r_prio   [NUM_SLOTS];
    logic [TIME_W-1:0]    r_wake   [NUM_SLOTS];
    logic [TIME_W-1:0]    r_tick;
    logic [SLOT_W-1:0]    r_cur;
    logic [SLOT_W-1:0]    r_idx;
    logic [SLOT_W-1:0]    r_cnt;
    logic [SLOT_W-1:0]    r_best;
    logic [PRIO_BITS-1:0] r_best_prio;
    logic                 r_have;
    logic [NUM_SLOTS-1:0] r_woken;
    logic                 r_done;
    logic                 r_switched;

    logic [SLOT_W-1:0]    n_idx;
    logic [SLOT_W-1:0]    n_best;
    logic                 accept;
    logic                 slot_ok;
    logic [SLOT_W-1:0]    slot_idx;
    t_cmd                 cmd;
    t_eval                eval;

    assign accept   = start && !busy;
    assign slot_ok  = (int'(i_task_slot) < NUM_SLOTS);
    assign slot_idx = SLOT_W'(i_task_slot);
    assign cmd      = t_cmd'(i_cmd);
    // circular successor of the scan index
    assign n_idx    = (r_idx == LAST_SLOT) ? '0 : r_idx + 1'b1;
    assign n_best   = eval.take ? r_idx : r_best;

    ptss_eval #(
        .PRIO_BITS (PRIO_BITS)
    ) u_eval (
        .i_wake_phase (r_state == S_WAKE),
        .i_status     (r_status[r_idx]),
        .i_wake_time  (r_wake[r_idx]),
        .i_tick       (r_tick),
        .i_prio       (r_prio[r_idx]),
        .i_best_prio  (r_best_prio),
        .i_have       (r_have),
        .o_eval       (eval)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_tick     <= '0;
            r_cur      <= '0;
            r_idx      <= '0;
            r_cnt      <= '0;
            r_best     <= '0;
            r_have     <= 1'b0;
            r_woken    <= '0;
            r_done     <= 1'b0;
            r_switched <= 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_status[i] <= ST_UNUSED;
                r_prio[i]   <= '0;
                r_wake[i]   <= WAKE_NEVER;
            end
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (cmd == CMD_TICK) begin
                            r_tick  <= r_tick + 1'b1;
                            r_idx   <= '0;
                            r_woken <= '0;
                            r_state <= S_WAKE;
                        end else begin
                            r_woken    <= '0;
                            r_switched <= 1'b0;
                            r_done     <= 1'b1;
                            unique case (cmd)
                                CMD_YIELD: begin
                                    if (slot_ok) begin
                                        r_cur      <= slot_idx;
                                        r_switched <= (slot_idx != r_cur);
                                    end
                                end
                                CMD_CREATE: begin
                                    if (slot_ok) begin
                                        r_status[slot_idx] <= ST_READY;
                                        r_prio[slot_idx]   <= '0;
                                        r_wake[slot_idx]   <= WAKE_NEVER;
                                    end
                                end
                                CMD_WAIT: begin
                                    if (slot_ok) begin
                                        r_status[slot_idx] <= ST_WAIT;
                                        r_wake[slot_idx]   <= i_due_time;
                                    end
                                end
                                CMD_SET_PRIO: begin
                                    if (slot_ok) begin
                                        r_prio[slot_idx] <= PRIO_BITS'(i_priority_value);
                                    end
                                end
                                default: begin
                                end
                            endcase
                        end
                    end
                end
                S_WAKE: begin
                    if (eval.wake_hit) begin
                        r_status[r_idx] <= ST_READY;
                        r_wake[r_idx]   <= WAKE_NEVER;
                        r_woken[r_idx]  <= 1'b1;
                    end
                    if (r_idx == LAST_SLOT) begin
                        r_idx   <= r_cur;
                        r_state <= S_INIT;
                    end else begin
                        r_idx <= n_idx;
                    end
                end
                S_INIT: begin
                    // the running slot starts as the holder when it is ready, so it wins ties
                    r_best      <= r_cur;
                    r_best_prio <= r_prio[r_idx];
                    r_have      <= (r_status[r_idx] == ST_READY);
                    r_idx       <= n_idx;
                    r_cnt       <= '0;
                    r_state     <= S_SCAN;
                end
                S_SCAN: begin
                    if (eval.take) begin
                        r_best      <= r_idx;
                        r_best_prio <= r_prio[r_idx];
                        r_have      <= 1'b1;
                    end
                    if (r_cnt == LAST_SLOT) begin
                        r_cur      <= n_best;
                        r_switched <= (n_best != r_cur);
                        r_done     <= 1'b1;
                        r_state    <= S_IDLE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                        r_idx <= n_idx;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_done         = r_done;
    assign o_running_slot = SLOT_FIELD_W'(r_cur);
    assign o_switched     = r_switched;
    assign o_woken_mask   = MASK_W'(r_woken);
    assign o_tick_now     = r_tick;

endmodule

`default_nettype wire

@@ hw/rtl/ptss_checker.sv @@
// port-level checks for the task scheduler, bound to the top level
`default_nettype none

module ptss_checker
    import ptss_pkg::*;
(
    input wire logic                    i_clk,
    input wire logic                    i_rst_n,
    input wire logic                    start,
    input wire logic                    busy,
    input wire logic [CMD_W-1:0]        i_cmd,
    input wire logic                    o_done,
    input wire logic [MASK_W-1:0]       o_woken_mask,
    input wire logic [TIME_W-1:0]       o_tick_now
);

    logic acc_tick;
    logic acc_other;

    assign acc_tick  = start && !busy && (i_cmd == CMD_TICK);
    assign acc_other = start && !busy && (i_cmd != CMD_TICK);

    // table commands answer in the next cycle
    a_other_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_other |=> o_done && (o_woken_mask == '0) && $stable(o_tick_now))
        else $error("non-tick transfer did not complete in one cycle");

    // a tick advances the counter once and keeps the block busy
    a_tick_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_tick |=> busy && !o_done && (o_tick_now == $past(o_tick_now) + 1'b1))
        else $error("tick did not advance the counter or enter the scan");

    // a result is never shown while a scan is still running
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    // the counter only moves on a tick transfer
    a_tick_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !acc_tick |=> $stable(o_tick_now))
        else $error("tick counter changed without a tick");

endmodule

bind priority_task_scheduler_with_sleep_unit ptss_checker u_ptss_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_cmd        (i_cmd),
    .o_done       (o_done),
    .o_woken_mask (o_woken_mask),
    .o_tick_now   (o_tick_now)
);

`default_nettype wire

@@ test/priority_task_scheduler_with_sleep_unit_tb.sv @@
// testbench for the priority task scheduler: directed and random commands against a predictor
`timescale 1ns / 100ps

module priority_task_scheduler_with_sleep_unit_tb;
    import ptss_pkg::*;

    localparam int SLOTS        = NUM_SLOTS_DEF;
    localparam int PBITS        = PRIO_BITS_DEF;
    localparam int TICK_LATENCY = 2 * SLOTS + 2;
    localparam int STALL_LIMIT  = 2000;
    localparam int CMD_UNDEF_LO = int'(CMD_SET_PRIO) + 1;
    localparam int CMD_UNDEF_HI = (1 << CMD_W) - 1;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [SLOT_FIELD_W-1:0] running;
        logic                    switched;
        logic [MASK_W-1:0]       woken;
        logic [TIME_W-1:0]       tick_now;
    } t_sched_result;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    start;
    logic                    busy;
    logic [CMD_W-1:0]        i_cmd;
    logic [SLOT_FIELD_W-1:0] i_task_slot;
    logic [TIME_W-1:0]       i_due_time;
    logic [PRIO_FIELD_W-1:0] i_priority_value;
    logic                    o_done;
    logic [SLOT_FIELD_W-1:0] o_running_slot;
    logic                    o_switched;
    logic [MASK_W-1:0]       o_woken_mask;
    logic [TIME_W-1:0]       o_tick_now;

    // predicted scheduler state
    logic [TIME_W-1:0]       sched_tick;
    t_status                 slot_state [SLOTS];
    logic [PBITS-1:0]        slot_prio  [SLOTS];
    logic [TIME_W-1:0]       slot_wake  [SLOTS];
    logic [SLOT_FIELD_W-1:0] run_slot;

    t_sched_result expected_results[$];
    int            mismatches = 0;
    int            stall_cycles;

    priority_task_scheduler_with_sleep_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_cmd            (i_cmd),
        .i_task_slot      (i_task_slot),
        .i_due_time       (i_due_time),
        .i_priority_value (i_priority_value),
        .o_done           (o_done),
        .o_running_slot   (o_running_slot),
        .o_switched       (o_switched),
        .o_woken_mask     (o_woken_mask),
        .o_tick_now       (o_tick_now)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // advance the predicted state by one command and queue the result it gives
    task automatic schedule_step(input logic [CMD_W-1:0] cmd,
                                 input logic [SLOT_FIELD_W-1:0] slot,
                                 input logic [TIME_W-1:0] due,
                                 input logic [PRIO_FIELD_W-1:0] prio);
        t_sched_result           res;
        logic [SLOT_FIELD_W-1:0] prev;
        int                      best;
        int                      idx;
        int                      i;
        bit                      have;
        bit                      in_range;
        prev      = run_slot;
        res.woken = '0;
        in_range  = int'(slot) < SLOTS;
        case (cmd)
            CMD_TICK: begin
                sched_tick = sched_tick + 1;
                for (i = 0; i < SLOTS; i++) begin
                    if (slot_state[i] == ST_WAIT && slot_wake[i] <= sched_tick) begin
                        slot_state[i] = ST_READY;
                        slot_wake[i]  = WAKE_NEVER;
                        res.woken[i]  = 1'b1;
                    end
                end
                // circular scan after the current slot, current wins ties only when ready
                best = int'(run_slot);
                have = slot_state[best] == ST_READY;
                idx  = best;
                for (i = 0; i < SLOTS; i++) begin
                    idx = (idx + 1) % SLOTS;
                    if (slot_state[idx] == ST_READY &&
                        (!have || slot_prio[idx] > slot_prio[best])) begin
                        best = idx;
                        have = 1'b1;
                    end
                end
                run_slot = SLOT_FIELD_W'(best);
            end
            CMD_YIELD: begin
                if (in_range) run_slot = slot;
            end
            CMD_CREATE: begin
                if (in_range) begin
                    slot_state[slot] = ST_READY;
                    slot_prio[slot]  = '0;
                    slot_wake[slot]  = WAKE_NEVER;
                end
            end
            CMD_WAIT: begin
                if (in_range) begin
                    slot_state[slot] = ST_WAIT;
                    slot_wake[slot]  = due;
                end
            end
            CMD_SET_PRIO: begin
                if (in_range) slot_prio[slot] = prio[PBITS-1:0];
            end
            default: begin
            end
        endcase
        res.running  = run_slot;
        res.switched = run_slot != prev;
        res.tick_now = sched_tick;
        expected_results.push_back(res);
    endtask

    // drive one command and hold it until the transfer; start is left high
    task automatic issue_command(input logic [CMD_W-1:0] cmd,
                                 input logic [SLOT_FIELD_W-1:0] slot,
                                 input logic [TIME_W-1:0] due,
                                 input logic [PRIO_FIELD_W-1:0] prio);
        @(negedge i_clk);
        start            <= 1'b1;
        i_cmd            <= cmd;
        i_task_slot      <= slot;
        i_due_time       <= due;
        i_priority_value <= prio;
        do @(posedge i_clk); while (busy);
        schedule_step(cmd, slot, due, prio);
    endtask

    task automatic idle_gap(input int cycles);
        @(negedge i_clk);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic issue_random();
        int                      pick;
        int                      mode;
        logic [CMD_W-1:0]        cmd;
        logic [SLOT_FIELD_W-1:0] slot;
        logic [TIME_W-1:0]       due;
        logic [PRIO_FIELD_W-1:0] prio;
        pick = $urandom_range(0, 99);
        slot = SLOT_FIELD_W'($urandom_range(0, SLOTS - 1));
        // small priorities give plenty of ties
        prio = $urandom_range(0, 1) ? PRIO_FIELD_W'($urandom_range(0, 3))
                                    : PRIO_FIELD_W'($urandom);
        due  = $urandom;
        if (pick < 35)      cmd = CMD_TICK;
        else if (pick < 45) cmd = CMD_YIELD;
        else if (pick < 60) cmd = CMD_CREATE;
        else if (pick < 80) cmd = CMD_WAIT;
        else if (pick < 95) cmd = CMD_SET_PRIO;
        else                cmd = CMD_W'($urandom_range(CMD_UNDEF_LO, CMD_UNDEF_HI));
        if (cmd == CMD_WAIT) begin
            mode = $urandom_range(0, 9);
            if (mode < 6)      due = sched_tick + $urandom_range(0, 8);
            else if (mode < 8) due = TIME_W'($urandom_range(0, sched_tick));
        end
        issue_command(cmd, slot, due, prio);
    endtask

    task automatic test_table_commands();
        issue_command(CMD_TICK, 3'd0, 32'h0, 8'h0);            // nothing ready, slot 0 stays
        issue_command(CMD_W'(CMD_UNDEF_LO), 3'd7, WAKE_NEVER, 8'hFF);
        issue_command(CMD_W'(CMD_UNDEF_HI), 3'd3, 32'h0, 8'h00);
        issue_command(CMD_YIELD, 3'd5, 32'h0, 8'h0);           // yield to an unused slot
        issue_command(CMD_TICK, 3'd0, 32'h0, 8'h0);
        issue_command(CMD_CREATE, 3'd2, 32'h0, 8'h0);
        issue_command(CMD_SET_PRIO, 3'd0, 32'h0, 8'hFF);       // priority on an unused slot
        issue_command(CMD_WAIT, 3'd4, 32'hAAAA5555, 8'h0);
        issue_command(CMD_WAIT, 3'd4, 32'h5555AAAA, 8'h0);
        issue_command(CMD_CREATE, 3'd4, 32'h0, 8'h0);
    endtask

    task automatic test_wake_and_select();
        issue_command(CMD_TICK, 3'd0, 32'h0, 8'h0);            // current not ready loses
        issue_command(CMD_CREATE, 3'd6, 32'h0, 8'h0);
        issue_command(CMD_TICK, 3'd0, 32'h0, 8'h0);            // tie, current keeps running
        issue_command(CMD_SET_PRIO, 3'd6, 32'h0, 8'hFF);
        issue_command(CMD_TICK, 3'd0, 32'h0, 8'h0);
        issue_command(CMD_WAIT, 3'd6, 32'h0, 8'h0);            // already due
        issue_command(CMD_TICK, 3'd0, 32'h0, 8'h0);
        issue_command(CMD_WAIT, 3'd2, WAKE_NEVER, 8'h0);
        issue_command(CMD_WAIT, 3'd4, WAKE_NEVER, 8'h0);
        issue_command(CMD_WAIT, 3'd6, sched_tick + 2, 8'h0);
        issue_command(CMD_TICK, 3'd0, 32'h0, 8'h0);            // nothing ready
        issue_command(CMD_TICK, 3'd0, 32'h0, 8'h0);            // due time reached exactly
        issue_command(CMD_CREATE, 3'd1, 32'h0, 8'h0);
        issue_command(CMD_SET_PRIO, 3'd1, 32'h0, 8'h01);
        issue_command(CMD_CREATE, 3'd3, 32'h0, 8'h0);
        issue_command(CMD_SET_PRIO, 3'd3, 32'h0, 8'h01);
        issue_command(CMD_SET_PRIO, 3'd6, 32'h0, 8'h00);
        issue_command(CMD_TICK, 3'd0, 32'h0, 8'h0);            // equal rivals, first in scan wins
    endtask

    task automatic test_random_traffic(input int count);
        int n;
        for (n = 0; n < count; n++) begin
            // every fourth stretch of 10 items runs without gaps
            if ((n % 40) >= 10 && $urandom_range(0, 3) == 0)
                idle_gap($urandom_range(1, 14));
            issue_random();
        end
    endtask

    task automatic test_back_to_back(input int count);
        repeat (count) issue_random();
    endtask

    // result checker: the receiver cannot stall, so every strobe is a transfer
    always @(posedge i_clk) begin
        t_sched_result exp_res;
        if (i_rst_n && o_done) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: slot=%0d sw=%0b mask=%02h tick=%08h",
                             o_running_slot, o_switched, o_woken_mask, o_tick_now);
            end else begin
                exp_res = expected_results.pop_front();
                if (o_running_slot !== exp_res.running || o_switched !== exp_res.switched ||
                    o_woken_mask !== exp_res.woken || o_tick_now !== exp_res.tick_now) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("mismatch: exp slot=%0d sw=%0b mask=%02h tick=%08h",
                                 exp_res.running, exp_res.switched, exp_res.woken,
                                 exp_res.tick_now,
                                 ", got slot=%0d sw=%0b mask=%02h tick=%08h",
                                 o_running_slot, o_switched, o_woken_mask, o_tick_now);
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int i;
        i_rst_n          = 1'b0;
        start            = 1'b0;
        i_cmd            = CMD_TICK;
        i_task_slot      = '0;
        i_due_time       = '0;
        i_priority_value = '0;
        sched_tick       = '0;
        run_slot         = '0;
        for (i = 0; i < SLOTS; i++) begin
            slot_state[i] = ST_UNUSED;
            slot_prio[i]  = '0;
            slot_wake[i]  = WAKE_NEVER;
        end
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_table_commands();
        test_wake_and_select();
        test_random_traffic(600);
        test_back_to_back(225);

        @(negedge i_clk);
        start <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (TICK_LATENCY + 4) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
